// ----- rtl/sha1_message_digest_defines.svh -----
// Assertion macros for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define SHA1MD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha1md: check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha1md: check failed");

`endif

// ----- rtl/sha1md_pkg.sv -----
package sha1md_pkg;

	// Round constants, one per group of twenty rounds
	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	// Initial chaining value, word 0 in the lowest slot
	localparam logic [4:0][31:0] IV_WORDS = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_BYTE       = 8'h80;
	localparam logic [7:0] ZERO_BYTE      = 8'h00;
	localparam logic [6:0] LAST_ROUND     = 7'd79;
	localparam logic [6:0] SCHED_ROUNDS   = 7'd16;
	localparam logic [6:0] GROUP1_START   = 7'd20;
	localparam logic [6:0] GROUP2_START   = 7'd40;
	localparam logic [6:0] GROUP3_START   = 7'd60;
	localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
	localparam logic [5:0] PAD_LAST_POS   = 6'd55;
	localparam logic [2:0] LAST_WORD_IDX  = 3'd4;

	// Control from the sequencer to the round unit
	typedef struct packed {
		logic       byte_we;   // shift one byte into the block buffer
		logic       word_end;  // this byte completes a 32-bit word
		logic [7:0] data;      // byte to write
		logic       start;     // run the compression from the next cycle
		logic       init;      // load the initial chaining value
	} sha1md_ctrl_t;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_HASH    = 7'b0000010,
		ST_PAD     = 7'b0000100,
		ST_PADHASH = 7'b0001000,
		ST_LEN     = 7'b0010000,
		ST_FINAL   = 7'b0100000,
		ST_OUT     = 7'b1000000
	} sha1md_state_t;

endpackage

// ----- rtl/sha1_message_digest.sv -----
// SHA-1 digest of a byte stream, one word of input per accepted byte or end mark.
// Ordinary byte: the input stays ready. A byte that fills a 64-byte block runs
// a compression (80 rounds, a fold, a return to intake) in the shared round unit.
// End mark: padding and length bytes, one per cycle, up to the block end, one or two
// compressions, then five digest words, one per cycle when taken.
// Reset (arst_n low) loads the initial hash words and clears counters and control.
`include "sha1_message_digest_defines.svh"

module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast    // last_word
);
	import sha1md_pkg::*;

	sha1md_state_t    state_q;
	logic [5:0]       pos_q;
	logic [63:0]      cnt_q;
	logic [63:0]      len_q;
	logic             end_q;
	logic             pad_first_q;
	logic [2:0]       out_idx_q;

	sha1md_ctrl_t     ctrl;
	logic             core_busy;
	logic [4:0][31:0] chain;
	logic             in_acc;
	logic             out_acc;
	logic [63:0]      cnt_next;

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.busy   (core_busy),
		.chain  (chain)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_acc       = m_axis_tvalid & m_axis_tready;
	assign m_axis_tdata  = chain[out_idx_q];
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = (out_idx_q == LAST_WORD_IDX);
	assign cnt_next      = cnt_q + {63'd0, in_acc & s_axis_tuser};

	// Drive the round unit: message, padding and length bytes, compress, reload
	always_comb begin
		ctrl      = '0;
		ctrl.data = ZERO_BYTE;
		case (state_q)
			ST_IDLE: begin
				ctrl.byte_we = in_acc & s_axis_tuser;
				ctrl.data    = s_axis_tdata;
			end
			ST_PAD: begin
				ctrl.byte_we = 1'b1;
				ctrl.data    = pad_first_q ? PAD_BYTE : ZERO_BYTE;
			end
			ST_LEN: begin
				ctrl.byte_we = 1'b1;
				ctrl.data    = len_q[63:56];
			end
			ST_OUT: begin
				ctrl.init = out_acc & m_axis_tlast;
			end
			default: begin
				ctrl.byte_we = 1'b0;
			end
		endcase
		ctrl.word_end = &pos_q[1:0];
		ctrl.start    = ctrl.byte_we & (pos_q == BLOCK_LAST_POS);
	end

	// Sequence message intake, padding, compression and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			end_q       <= 1'b0;
			pad_first_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (ctrl.byte_we) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (s_axis_tlast) begin
							len_q       <= {cnt_next[60:0], 3'b000};
							pad_first_q <= 1'b1;
						end
						if (ctrl.start) begin
							end_q   <= s_axis_tlast;
							state_q <= ST_HASH;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_HASH: begin
					if (!core_busy) begin
						state_q <= end_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (pos_q == BLOCK_LAST_POS) begin
						state_q <= ST_PADHASH;
					end else if (pos_q == PAD_LAST_POS) begin
						state_q <= ST_LEN;
					end
				end
				ST_PADHASH: begin
					if (!core_busy) begin
						state_q <= ST_PAD;
					end
				end
				ST_LEN: begin
					len_q <= {len_q[55:0], 8'h00};
					if (pos_q == BLOCK_LAST_POS) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (!core_busy) begin
						out_idx_q <= '0;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (m_axis_tlast) begin
							cnt_q   <= '0;
							pos_q   <= '0;
							end_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on sequencer and round unit interplay
	`SHA1MD_ASSERT_IMPL(a_ready_core_idle, s_axis_tready, !core_busy)
	`SHA1MD_ASSERT_IMPL(a_out_not_ready, m_axis_tvalid, !s_axis_tready && !core_busy)
	`SHA1MD_ASSERT_NEXT(a_last_to_idle, out_acc && m_axis_tlast, s_axis_tready && pos_q == 6'd0)
	`SHA1MD_ASSERT_NEXT(a_start_runs, ctrl.start, core_busy)

endmodule

// ----- rtl/sha1md_core.sv -----
module sha1md_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sha1md_pkg::sha1md_ctrl_t   ctrl,
	output logic                       busy,
	output logic [4:0][31:0]           chain
);
	import sha1md_pkg::*;

	logic [15:0][31:0] sched_q;
	logic [23:0]       acc_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [4:0][31:0]  chain_q;
	logic [6:0]        rnd_q;
	logic              run_q;
	logic              add_q;

	logic [31:0] mix;
	logic [31:0] w_new;
	logic [31:0] w_cur;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;

	// Message schedule: next word from the sixteen-word window
	assign mix   = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_new = {mix[30:0], mix[31]};
	assign w_cur = (rnd_q < SCHED_ROUNDS) ? sched_q[0] : w_new;

	// Round function and constant by round group
	always_comb begin
		if (rnd_q < GROUP1_START) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (rnd_q < GROUP2_START) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (rnd_q < GROUP3_START) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

	// Gather bytes big-endian; shift full words and schedule words into the window
	always_ff @(posedge clk) begin
		if (ctrl.byte_we) begin
			acc_q <= {acc_q[15:0], ctrl.data};
		end
		if (ctrl.byte_we && ctrl.word_end) begin
			sched_q <= {{acc_q, ctrl.data}, sched_q[15:1]};
		end else if (run_q) begin
			sched_q <= {w_cur, sched_q[15:1]};
		end
	end

	// Round sequencer: load, 80 rounds, fold into the chaining value; init reloads the initial value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			add_q   <= 1'b0;
			rnd_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			e_q     <= '0;
			chain_q <= IV_WORDS;
		end else if (ctrl.start) begin
			run_q <= 1'b1;
			rnd_q <= '0;
			a_q   <= chain_q[0];
			b_q   <= chain_q[1];
			c_q   <= chain_q[2];
			d_q   <= chain_q[3];
			e_q   <= chain_q[4];
		end else if (run_q) begin
			a_q   <= t_val;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
			rnd_q <= rnd_q + 7'd1;
			if (rnd_q == LAST_ROUND) begin
				run_q <= 1'b0;
				add_q <= 1'b1;
			end
		end else if (add_q) begin
			add_q      <= 1'b0;
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end else if (ctrl.init) begin
			chain_q <= IV_WORDS;
		end
	end

	assign busy  = run_q | add_q;
	assign chain = chain_q;

endmodule
